// ===== sv/mrcr_pkg.sv =====
package mrcr_pkg;

    // default panel edge length in pixels
    localparam int DISPLAY_SIZE_DEF = 96;

    // input word actions
    typedef enum logic {
        ACT_START = 1'b0,
        ACT_NEXT  = 1'b1
    } t_action;

    // input word
    typedef struct packed {
        t_action     action;
        logic [6:0]  center_x;
        logic [6:0]  center_y;
        logic [6:0]  radius;
        logic [4:0]  ring_count;
        logic [15:0] colour;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] pixel_colour;
        logic        on_screen;
        logic        last;
    } t_out_word;

    // registered input stage as seen by the core
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_stage;

endpackage

// ===== sv/mrcr_in_stage.sv =====
module mrcr_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mrcr_pkg::t_in_word i_word,
    input  logic              i_advance,
    output mrcr_pkg::t_stage  o_stage
);

    logic               r_valid;
    logic               n_valid;
    mrcr_pkg::t_in_word r_word;

    // stage is free when empty or moving on this cycle
    assign o_ready = !r_valid || i_advance;

    // valid tracking
    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // word capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.word  = r_word;

endmodule

// ===== sv/mrcr_ring_core.sv =====
module mrcr_ring_core #(
    parameter int DISPLAY_SIZE = mrcr_pkg::DISPLAY_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  mrcr_pkg::t_in_word  i_word,
    output mrcr_pkg::t_out_word o_result
);

    localparam logic [7:0] LIMIT = 8'(DISPLAY_SIZE - 1);

    // drawing state
    logic               r_busy, n_busy;
    logic [6:0]         r_cx, n_cx;
    logic [6:0]         r_cy, n_cy;
    logic [15:0]        r_colour, n_colour;
    logic [4:0]         r_rings, n_rings;
    logic [7:0]         r_rad, n_rad;
    logic signed [7:0]  r_off_x, n_off_x;
    logic signed [7:0]  r_off_y, n_off_y;
    logic signed [9:0]  r_dec, n_dec;
    logic [2:0]         r_oct, n_oct;

    // point arithmetic
    logic [7:0]         dx, dy;
    logic [7:0]         px, py;
    logic [7:0]         start_rad;
    logic signed [9:0]  dec_a, dec_b;
    logic signed [7:0]  x_step, y_step;
    logic               ring_done;

    // octant mirror select
    always_comb begin
        case (r_oct)
            3'd0: begin dx = r_off_x;  dy = r_off_y;  end
            3'd1: begin dx = r_off_x;  dy = -r_off_y; end
            3'd2: begin dx = -r_off_x; dy = r_off_y;  end
            3'd3: begin dx = -r_off_x; dy = -r_off_y; end
            3'd4: begin dx = r_off_y;  dy = r_off_x;  end
            3'd5: begin dx = r_off_y;  dy = -r_off_x; end
            3'd6: begin dx = -r_off_y; dy = r_off_x;  end
            default: begin dx = -r_off_y; dy = -r_off_x; end
        endcase
    end

    // pixel position wraps at 8 bits
    assign px = {1'b0, r_cx} + dx;
    assign py = {1'b0, r_cy} + dy;

    // midpoint step taken after the eighth mirror
    assign dec_a  = r_dec + {r_off_x[7], r_off_x, 1'b0} + 10'sd1;
    assign x_step = r_off_x + 8'sd1;
    assign dec_b  = dec_a + 10'sd1 - {r_off_y[7], r_off_y, 1'b0};
    assign y_step = dec_a[9] ? r_off_y : r_off_y - 8'sd1;
    assign ring_done = y_step < x_step;

    assign start_rad = {1'b0, i_word.radius} + {4'd0, i_word.ring_count[4:1]};

    // next state
    always_comb begin
        n_busy   = r_busy;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_colour = r_colour;
        n_rings  = r_rings;
        n_rad    = r_rad;
        n_off_x  = r_off_x;
        n_off_y  = r_off_y;
        n_dec    = r_dec;
        n_oct    = r_oct;
        if (i_advance) begin
            if (i_word.action == mrcr_pkg::ACT_START) begin
                n_cx     = i_word.center_x;
                n_cy     = i_word.center_y;
                n_colour = i_word.colour;
                n_rad    = start_rad;
                n_rings  = (i_word.ring_count == 5'd0) ? 5'd0 : i_word.ring_count - 5'd1;
                n_busy   = i_word.ring_count != 5'd0;
                n_off_x  = 8'sd0;
                n_off_y  = start_rad;
                n_dec    = 10'sd0;
                n_oct    = 3'd0;
            end else if (r_busy) begin
                n_oct = r_oct + 3'd1;
                if (r_oct == 3'd7) begin
                    n_off_x = x_step;
                    n_off_y = y_step;
                    n_dec   = dec_a[9] ? dec_a : dec_b;
                    if (ring_done) begin
                        if (r_rings == 5'd0 || r_rad == 8'd0) begin
                            n_busy = 1'b0;
                        end else begin
                            // next ring one pixel further in
                            n_rings = r_rings - 5'd1;
                            n_rad   = r_rad - 8'd1;
                            n_off_x = 8'sd0;
                            n_off_y = r_rad - 8'd1;
                            n_dec   = 10'sd0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_colour <= '0;
            r_rings  <= '0;
            r_rad    <= '0;
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_dec    <= '0;
            r_oct    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_colour <= n_colour;
            r_rings  <= n_rings;
            r_rad    <= n_rad;
            r_off_x  <= n_off_x;
            r_off_y  <= n_off_y;
            r_dec    <= n_dec;
            r_oct    <= n_oct;
        end
    end

    // result word, blank point with last set when idle
    always_comb begin
        if (r_busy) begin
            o_result.pixel_x      = px;
            o_result.pixel_y      = py;
            o_result.pixel_colour = r_colour;
            o_result.on_screen    = (px <= LIMIT) && (py <= LIMIT);
            o_result.last         = !n_busy;
        end else begin
            o_result.pixel_x      = 8'd0;
            o_result.pixel_y      = 8'd0;
            o_result.pixel_colour = 16'd0;
            o_result.on_screen    = 1'b0;
            o_result.last         = 1'b1;
        end
    end

endmodule

// ===== sv/mrcr_out_stage.sv =====
module mrcr_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mrcr_pkg::t_out_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output mrcr_pkg::t_out_word o_word
);

    logic                r_valid;
    logic                n_valid;
    mrcr_pkg::t_out_word r_word;

    // valid tracking
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== sv/multi_ring_circle_rasterizer.sv =====
// Multi-ring circle rasterizer. A start word loads center, radius, ring count and colour
// and produces no result; each next word returns one pixel, walking ring_count concentric
// midpoint circles from radius+ring_count/2 inward, eight mirrored points per step. A next
// word while no shape is pending returns a blank point with last set. Words pass through an
// input register and the point logic into an output register, so one word is taken every
// cycle while the output side keeps up; the input register holds each word, the point
// logic turns it into a point combinationally, and the output register then captures
// the point.
module multi_ring_circle_rasterizer #(
    parameter int DISPLAY_SIZE = mrcr_pkg::DISPLAY_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mrcr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mrcr_pkg::t_out_word o_out_word
);

    mrcr_pkg::t_stage    stage;
    mrcr_pkg::t_out_word result;
    logic                is_start;
    logic                advance;
    logic                load;

    // a start word never waits on the output register
    assign is_start = stage.word.action == mrcr_pkg::ACT_START;
    assign advance  = stage.valid && (is_start || !o_out_valid || i_out_ready);
    assign load     = advance && !is_start;

    mrcr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_word    (i_in_word),
        .i_advance (advance),
        .o_stage   (stage)
    );

    mrcr_ring_core #(
        .DISPLAY_SIZE (DISPLAY_SIZE)
    ) u_ring_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (stage.word),
        .o_result  (result)
    );

    mrcr_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_word  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule
